@@ rtl/adcavg_pkg.sv @@
// Shared types, constants and saturation helpers for the ADC batch averager.
package adcavg_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int FULL_SCALE = 4095;
    localparam int REF_UV     = 3000000;
    localparam int CUR_SCALE  = 256000000;

    localparam int NUM_W  = 56;
    localparam int DEN_W  = 36;
    localparam int CNT_W  = 6;
    localparam int PROD_W = 34;
    localparam int PDEN_W = 24;
    localparam int PNUM_W = 46;
    localparam int CNUM_W = 52;

    localparam int CFG_W  = 20;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_GROUPS = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIV    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_OHMS   = 3'd4;

    localparam logic [23:0] SAT24 = 24'hFFFFFF;
    localparam logic [31:0] SAT32 = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        S_ACC,
        S_AVG_START,
        S_AVG_WAIT,
        S_PREP,
        S_SUP_START,
        S_SUP_WAIT,
        S_PIN_MUL,
        S_PIN_START,
        S_PIN_WAIT,
        S_FIN_MUL,
        S_CUR_CHK,
        S_CUR_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_AVG_START,
        OP_AVG_STORE,
        OP_PREP,
        OP_SUP_START,
        OP_SUP_STORE,
        OP_PIN_MUL,
        OP_PIN_START,
        OP_PIN_STORE,
        OP_FIN_MUL,
        OP_CUR_START,
        OP_CUR_STORE,
        OP_LOAD
    } dp_op_t;

    typedef struct packed {
        logic        accept_en;
        dp_op_t      op;
        logic [1:0]  idx;
    } dp_cmd_t;

    typedef struct packed {
        logic batch_done;
        logic div_done;
        logic ref_zero;
        logic cur_den_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic [11:0] sat12(input logic [NUM_W-1:0] v);
        return (v > NUM_W'(FULL_SCALE)) ? 12'(FULL_SCALE) : v[11:0];
    endfunction

    function automatic logic [23:0] sat24(input logic [NUM_W-1:0] v);
        return (v > NUM_W'(SAT24)) ? SAT24 : v[23:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [NUM_W-1:0] v);
        return (v > NUM_W'(SAT32)) ? SAT32 : v[31:0];
    endfunction

endpackage

@@ rtl/adcavg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module adcavg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [adcavg_pkg::NUM_W-1:0]   num,
    input  logic [adcavg_pkg::DEN_W-1:0]   den,
    output logic                           done,
    output logic [adcavg_pkg::NUM_W-1:0]   quo
);
    import adcavg_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/adcavg_ctrl.sv @@
// Controller sequencing accumulation and the end-of-batch arithmetic.
module adcavg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  adcavg_pkg::dp_status_t  st,
    output adcavg_pkg::dp_cmd_t     cmd
);
    import adcavg_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.accept_en = 1'b0;
        cmd.op        = OP_NONE;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.accept_en = 1'b1;
                if (st.batch_done)
                begin
                    idx_next   = '0;
                    state_next = S_AVG_START;
                end
            end
            S_AVG_START:
            begin
                cmd.op     = OP_AVG_START;
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op = OP_AVG_STORE;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = S_PREP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_AVG_START;
                    end
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = st.ref_zero ? S_OUT : S_SUP_START;
            end
            S_SUP_START:
            begin
                cmd.op     = OP_SUP_START;
                state_next = S_SUP_WAIT;
            end
            S_SUP_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SUP_STORE;
                    idx_next   = '0;
                    state_next = S_PIN_MUL;
                end
            end
            S_PIN_MUL:
            begin
                cmd.op     = OP_PIN_MUL;
                state_next = S_PIN_START;
            end
            S_PIN_START:
            begin
                cmd.op     = OP_PIN_START;
                state_next = S_PIN_WAIT;
            end
            S_PIN_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op = OP_PIN_STORE;
                    if (idx_reg == 2'd2)
                    begin
                        state_next = S_FIN_MUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_PIN_MUL;
                    end
                end
            end
            S_FIN_MUL:
            begin
                cmd.op     = OP_FIN_MUL;
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK:
            begin
                if (st.cur_den_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_CUR_START;
                    state_next = S_CUR_WAIT;
                end
            end
            S_CUR_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_CUR_STORE;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

endmodule

@@ rtl/adcavg_dp.sv @@
// Datapath: channel sums, multipliers, shared divider and result register.
module adcavg_dp #(
    parameter int MAX_GROUPS = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [8:0]              groups_per_batch,
    input  logic [11:0]             reference_calibration,
    input  logic [15:0]             divider_ratio_q8,
    input  logic [15:0]             monitor_gain_q8,
    input  logic [19:0]             shunt_micro_ohms,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [11:0]             sample,
    input  logic                    batch_start,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [11:0]             avg_raw_main,
    output logic [11:0]             avg_raw_shunt,
    output logic [11:0]             avg_raw_aux,
    output logic [11:0]             avg_raw_reference,
    output logic [23:0]             supply_uv,
    output logic [23:0]             main_pin_uv,
    output logic [31:0]             main_rail_uv,
    output logic [23:0]             shunt_monitor_uv,
    output logic [23:0]             aux_pin_uv,
    output logic [31:0]             shunt_current_ua,
    output logic                    reference_zero,
    input  adcavg_pkg::dp_cmd_t     cmd,
    output adcavg_pkg::dp_status_t  st
);
    import adcavg_pkg::*;

    localparam int SUM_W = $clog2(MAX_GROUPS * FULL_SCALE + 1);
    localparam int NW    = $clog2(MAX_GROUPS + 1);
    localparam int POS_W = $clog2(MAX_GROUPS * CHANNELS + 1);

    logic [SUM_W-1:0]  sum_reg [CHANNELS];
    logic [SUM_W-1:0]  sum_next [CHANNELS];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  base_pos, pos_inc;
    logic [NW-1:0]     n_eff;
    logic              accept, hit;

    logic [11:0]       avg_reg [CHANNELS];
    logic [23:0]       sup_reg;
    logic [23:0]       pin_reg [3];
    logic [31:0]       rail_reg;
    logic [31:0]       cur_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PDEN_W-1:0] pden_reg;
    logic [PNUM_W-1:0] pnum_reg;
    logic [DEN_W-1:0]  cden_reg;
    logic [CNUM_W-1:0] cnum_reg;

    logic              out_valid_reg, out_valid_next;
    logic              load;
    logic              ref_zero;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]  div_den;

    always_comb
    begin
        if (groups_per_batch == 9'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(groups_per_batch) > MAX_GROUPS)
        begin
            n_eff = NW'(MAX_GROUPS);
        end
        else
        begin
            n_eff = NW'(groups_per_batch);
        end
    end

    assign accept   = in_valid && cmd.accept_en;
    assign in_stall = !cmd.accept_en;
    assign base_pos = batch_start ? '0 : pos_reg;
    assign pos_inc  = base_pos + POS_W'(1);
    assign hit      = (32'(pos_inc) >= 32'(n_eff) * CHANNELS);
    assign load     = (cmd.op == OP_LOAD);
    assign ref_zero = (avg_reg[3] == 12'd0);

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = sum_reg[c];
            if (load)
            begin
                sum_next[c] = '0;
            end
            else if (accept)
            begin
                sum_next[c] = (batch_start ? '0 : sum_reg[c])
                            + ((base_pos[CH_W-1:0] == CH_W'(c)) ? SUM_W'(sample) : '0);
            end
        end
        pos_next = pos_reg;
        if (load)
        begin
            pos_next = '0;
        end
        else if (accept)
        begin
            pos_next = pos_inc;
        end
    end

    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            OP_AVG_START:
            begin
                div_num = NUM_W'(sum_reg[cmd.idx]) + NUM_W'(n_eff >> 1);
                div_den = DEN_W'(n_eff);
            end
            OP_SUP_START:
            begin
                div_num = NUM_W'(prod_reg) + NUM_W'(avg_reg[3] >> 1);
                div_den = DEN_W'(avg_reg[3]);
            end
            OP_PIN_START:
            begin
                div_num = NUM_W'(pnum_reg) + NUM_W'(pden_reg >> 1);
                div_den = DEN_W'(pden_reg);
            end
            OP_CUR_START:
            begin
                div_num = NUM_W'(cnum_reg) + NUM_W'(cden_reg >> 1);
                div_den = cden_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    adcavg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_AVG_STORE: avg_reg[cmd.idx] <= sat12(div_quo);
            OP_PREP:
            begin
                prod_reg <= PROD_W'(REF_UV) * PROD_W'(reference_calibration);
                pden_reg <= PDEN_W'(avg_reg[3]) * PDEN_W'(FULL_SCALE);
            end
            OP_SUP_STORE: sup_reg <= sat24(div_quo);
            OP_PIN_MUL:   pnum_reg <= PNUM_W'(prod_reg) * PNUM_W'(avg_reg[cmd.idx]);
            OP_PIN_STORE: pin_reg[cmd.idx] <= sat24(div_quo);
            OP_FIN_MUL:
            begin
                rail_reg <= 32'((40'(pin_reg[0]) * 40'(divider_ratio_q8) + 40'd128) >> 8);
                cden_reg <= DEN_W'(monitor_gain_q8) * DEN_W'(shunt_micro_ohms);
                cnum_reg <= CNUM_W'(pin_reg[1]) * CNUM_W'(CUR_SCALE);
            end
            OP_CUR_STORE: cur_reg <= sat32(div_quo);
            OP_LOAD:
            begin
                avg_raw_main      <= avg_reg[0];
                avg_raw_shunt     <= avg_reg[1];
                avg_raw_aux       <= avg_reg[2];
                avg_raw_reference <= avg_reg[3];
                supply_uv         <= ref_zero ? SAT24 : sup_reg;
                main_pin_uv       <= ref_zero ? SAT24 : pin_reg[0];
                shunt_monitor_uv  <= ref_zero ? SAT24 : pin_reg[1];
                aux_pin_uv        <= ref_zero ? SAT24 : pin_reg[2];
                main_rail_uv      <= ref_zero ? SAT32 : rail_reg;
                shunt_current_ua  <= (ref_zero || cden_reg == '0) ? SAT32 : cur_reg;
                reference_zero    <= ref_zero;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign st.batch_done   = accept && hit;
    assign st.div_done     = div_done;
    assign st.ref_zero     = ref_zero;
    assign st.cur_den_zero = (cden_reg == '0);
    assign st.out_free     = !out_valid_reg || !out_stall;

endmodule

@@ rtl/adc_batch_average_ratiometric.sv @@
// Top level of the ADC batch averager with reference-based supply calibration.
// Usage:
//   Input channel (in_valid/in_stall): one 12-bit sample per item, interleaved
//   main, shunt, aux, reference. batch_start clears the sums before the item.
//   Each sample item is taken in one cycle while accumulating.
//   After the last item of a batch the block stalls its input while nine
//   divisions (four averages, supply, three pin voltages, current) run
//   one after another on one shared radix-2 divider, with preparation and
//   multiply steps between them. A zero reference average skips all but the
//   four averages, and a zero current denominator skips the current division.
//   The result item then appears on the output channel (out_valid/out_stall)
//   and input resumes. A batch is 4*groups items followed by this compute phase.
//   The result is held in an output register; while the receiver stalls,
//   accumulation of the next batch continues and only the next result waits.
//   Config writes (cfg_write/cfg_index/cfg_data) take effect at once; unknown
//   indexes are ignored.
//   Reset clears sums, position, output valid and restores register defaults.
module adc_batch_average_ratiometric #(
    parameter int MAX_GROUPS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] sample,
    input  logic        batch_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] avg_raw_main,
    output logic [11:0] avg_raw_shunt,
    output logic [11:0] avg_raw_aux,
    output logic [11:0] avg_raw_reference,
    output logic [23:0] supply_uv,
    output logic [23:0] main_pin_uv,
    output logic [31:0] main_rail_uv,
    output logic [23:0] shunt_monitor_uv,
    output logic [23:0] aux_pin_uv,
    output logic [31:0] shunt_current_ua,
    output logic        reference_zero
);
    import adcavg_pkg::*;

    logic [8:0]  groups_reg;
    logic [11:0] cal_reg;
    logic [15:0] div_reg;
    logic [15:0] gain_reg;
    logic [19:0] ohms_reg;

    dp_cmd_t    cmd;
    dp_status_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg <= 9'd1;
            cal_reg    <= 12'd1670;
            div_reg    <= 16'd512;
            gain_reg   <= 16'd12800;
            ohms_reg   <= 20'd15000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GROUPS: groups_reg <= cfg_data[8:0];
                REG_CAL:    cal_reg    <= cfg_data[11:0];
                REG_DIV:    div_reg    <= cfg_data[15:0];
                REG_GAIN:   gain_reg   <= cfg_data[15:0];
                REG_OHMS:   ohms_reg   <= cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    adcavg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    adcavg_dp #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .groups_per_batch      (groups_reg),
        .reference_calibration (cal_reg),
        .divider_ratio_q8      (div_reg),
        .monitor_gain_q8       (gain_reg),
        .shunt_micro_ohms      (ohms_reg),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .sample                (sample),
        .batch_start           (batch_start),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .avg_raw_main          (avg_raw_main),
        .avg_raw_shunt         (avg_raw_shunt),
        .avg_raw_aux           (avg_raw_aux),
        .avg_raw_reference     (avg_raw_reference),
        .supply_uv             (supply_uv),
        .main_pin_uv           (main_pin_uv),
        .main_rail_uv          (main_rail_uv),
        .shunt_monitor_uv      (shunt_monitor_uv),
        .aux_pin_uv            (aux_pin_uv),
        .shunt_current_ua      (shunt_current_ua),
        .reference_zero        (reference_zero),
        .cmd                   (cmd),
        .st                    (st)
    );

endmodule
